>>> hdl/mrmr_pkg.sv
// ----------------------------------------------------------------------------
// mrmr_pkg
// Shared types and constants of the mirrored region memory router.
// ----------------------------------------------------------------------------
`default_nettype none

package mrmr_pkg;

  localparam int unsigned MAIN_BYTES    = 65536;
  localparam int unsigned SECOND_BYTES  = 65536;
  localparam int unsigned SCRATCH_BYTES = 16384;

  localparam int unsigned MAIN_AW    = $clog2(MAIN_BYTES);
  localparam int unsigned SECOND_AW  = $clog2(SECOND_BYTES);
  localparam int unsigned SCRATCH_AW = $clog2(SCRATCH_BYTES);

  localparam int unsigned OFF_W0 = (MAIN_AW > SECOND_AW) ? MAIN_AW : SECOND_AW;
  localparam int unsigned OFF_W  = (OFF_W0 > SCRATCH_AW) ? OFF_W0 : SCRATCH_AW;

  localparam int unsigned MAX_BYTES0 = (MAIN_BYTES > SECOND_BYTES) ? MAIN_BYTES : SECOND_BYTES;
  localparam int unsigned MAX_BYTES  = (MAX_BYTES0 > SCRATCH_BYTES) ? MAX_BYTES0 : SCRATCH_BYTES;
  localparam int unsigned CLR_W      = $clog2(MAX_BYTES);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] SPAD_BASE_RESET = 32'hE000_0000;
  localparam logic [ADDR_W-1:0] CACHED_LO       = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] CACHED_HI       = 32'h8180_0000;
  localparam logic [ADDR_W-1:0] UNCACHED_LO     = 32'hC000_0000;
  localparam logic [ADDR_W-1:0] UNCACHED_HI     = 32'hC180_0000;
  localparam logic [ADDR_W-1:0] SEC_CACHED_LO   = 32'h9000_0000;
  localparam logic [ADDR_W-1:0] SEC_CACHED_HI   = 32'h9400_0000;
  localparam logic [ADDR_W-1:0] SEC_UNCACHED_LO = 32'hD000_0000;
  localparam logic [ADDR_W-1:0] SEC_UNCACHED_HI = 32'hD400_0000;
  localparam logic [ADDR_W-1:0] MAIN_MASK       = 32'h01FF_FFFF;
  localparam logic [ADDR_W-1:0] SECOND_SEL      = 32'h1000_0000;
  localparam logic [ADDR_W-1:0] SECOND_MASK     = 32'h03FF_FFFF;
  localparam logic [BYTE_W-1:0] UNMAPPED_BYTE   = 8'hFF;

  typedef enum logic [1:0] {
    REGION_SCRATCH = 2'd0,
    REGION_MAIN    = 2'd1,
    REGION_SECOND  = 2'd2,
    REGION_NONE    = 2'd3
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECOND_EN = 1'b0,
    CFG_SPAD_BASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_e;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  typedef struct packed {
    logic              second_en;
    logic [ADDR_W-1:0] spad_base;
  } cfg_t;

  typedef struct packed {
    logic              is_write;
    region_e           region;
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] wbyte;
    logic              first;
    logic              last;
  } byte_op_t;

endpackage

`default_nettype wire

>>> hdl/mrmr_ram.sv
// ----------------------------------------------------------------------------
// mrmr_ram
// Byte-wide single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmr_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/mrmr_queue.sv
// ----------------------------------------------------------------------------
// mrmr_queue
// Short queue of decoded byte operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmr_queue
  import mrmr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire byte_op_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output byte_op_t      pop_data_o,
  output logic          empty_o
);

  byte_op_t            entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mrmr_front.sv
// ----------------------------------------------------------------------------
// mrmr_front
// Accepts bus accesses, splits them into bytes and decodes each byte address.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmr_front
  import mrmr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              clearing_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              req_type_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [1:0]        access_size_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  output logic                   push_o,
  output byte_op_t               push_data_o,
  input  wire logic              full_i
);

  logic              busy_q, busy_d;
  logic [1:0]        k_q, k_d;
  logic [1:0]        kl_q, kl_d;
  logic              wr_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;
  logic              accept, last;

  logic [ADDR_W-1:0] byte_addr;
  logic [ADDR_W:0]   spad_diff;
  logic [ADDR_W-1:0] phys;
  logic [ADDR_W-1:0] sec_off;
  logic [1:0]        shift;

  assign last       = (k_q == kl_q);
  assign push_o     = busy_q && !full_i;
  assign in_stall_o = clearing_i || (busy_q && !(push_o && last));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    byte_addr = addr_q + ADDR_W'(k_q);
    spad_diff = {1'b0, byte_addr} - {1'b0, cfg_i.spad_base};
    if ((byte_addr >= CACHED_LO && byte_addr < CACHED_HI) ||
        (byte_addr >= UNCACHED_LO && byte_addr < UNCACHED_HI)) begin
      phys = byte_addr & MAIN_MASK;
    end else if ((byte_addr >= SEC_CACHED_LO && byte_addr < SEC_CACHED_HI) ||
                 (byte_addr >= SEC_UNCACHED_LO && byte_addr < SEC_UNCACHED_HI)) begin
      phys = byte_addr | SECOND_SEL;
    end else begin
      phys = byte_addr;
    end
    sec_off = phys & SECOND_MASK;
    shift   = kl_q - k_q;

    push_data_o.is_write = wr_q;
    push_data_o.first    = (k_q == 2'd0);
    push_data_o.last     = last;
    case (shift)
      2'd0:    push_data_o.wbyte = wdata_q[7:0];
      2'd1:    push_data_o.wbyte = wdata_q[15:8];
      2'd2:    push_data_o.wbyte = wdata_q[23:16];
      default: push_data_o.wbyte = wdata_q[31:24];
    endcase

    if (!spad_diff[ADDR_W] && spad_diff[ADDR_W-1:0] < ADDR_W'(SCRATCH_BYTES)) begin
      push_data_o.region = REGION_SCRATCH;
      push_data_o.offset = OFF_W'(spad_diff[SCRATCH_AW-1:0]);
    end else if (phys < ADDR_W'(MAIN_BYTES)) begin
      push_data_o.region = REGION_MAIN;
      push_data_o.offset = OFF_W'(phys[MAIN_AW-1:0]);
    end else if (cfg_i.second_en && (phys & SECOND_SEL) != '0 &&
                 sec_off < ADDR_W'(SECOND_BYTES)) begin
      push_data_o.region = REGION_SECOND;
      push_data_o.offset = OFF_W'(sec_off[SECOND_AW-1:0]);
    end else begin
      push_data_o.region = REGION_NONE;
      push_data_o.offset = '0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    kl_d   = kl_q;
    if (push_o) begin
      k_d = k_q + 2'd1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      k_d    = 2'd0;
      case (access_size_i)
        SIZE_BYTE: kl_d = 2'd0;
        SIZE_HALF: kl_d = 2'd1;
        default:   kl_d = 2'd3;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= 2'd0;
      kl_q   <= 2'd0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      kl_q   <= kl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_q    <= req_type_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mrmr_back.sv
// ----------------------------------------------------------------------------
// mrmr_back
// Clears the three stores after reset, carries out byte operations on them and assembles results.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmr_back
  import mrmr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     empty_i,
  input  wire byte_op_t op_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output logic [DATA_W-1:0] read_data_o,
  output logic [1:0]    region_o
);

  logic              clr_busy_q, clr_busy_d;
  logic [CLR_W-1:0]  clr_cnt_q, clr_cnt_d;

  logic              s1_vld_q, s1_vld_d;
  logic              s1_wr_q, s1_first_q, s1_last_q;
  region_e           s1_region_q;
  region_e           rgn_q;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              out_vld_q, out_vld_d;
  logic              s1_adv, s1_fire, out_load;
  logic [BYTE_W-1:0] rd_byte;
  region_e           first_region;

  logic              main_we, main_re, sec_we, sec_re, spad_we, spad_re;
  logic [MAIN_AW-1:0]    main_addr;
  logic [SECOND_AW-1:0]  sec_addr;
  logic [SCRATCH_AW-1:0] spad_addr;
  logic [BYTE_W-1:0]     wbyte;
  logic [BYTE_W-1:0]     main_rd, sec_rd, spad_rd;

  assign clearing_o  = clr_busy_q;
  assign out_valid_o = out_vld_q;

  assign s1_adv   = !s1_vld_q || !(s1_last_q && out_vld_q && out_stall_i);
  assign pop_o    = !empty_i && s1_adv && !clr_busy_q;
  assign s1_fire  = s1_vld_q && s1_adv;
  assign out_load = s1_fire && s1_last_q;

  always_comb begin
    main_we = 1'b0;
    sec_we  = 1'b0;
    spad_we = 1'b0;
    wbyte   = op_i.wbyte;
    if (clr_busy_q) begin
      main_we   = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(MAIN_BYTES));
      sec_we    = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(SECOND_BYTES));
      spad_we   = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(SCRATCH_BYTES));
      main_addr = clr_cnt_q[MAIN_AW-1:0];
      sec_addr  = clr_cnt_q[SECOND_AW-1:0];
      spad_addr = clr_cnt_q[SCRATCH_AW-1:0];
      wbyte     = '0;
    end else begin
      main_addr = op_i.offset[MAIN_AW-1:0];
      sec_addr  = op_i.offset[SECOND_AW-1:0];
      spad_addr = op_i.offset[SCRATCH_AW-1:0];
      if (pop_o && op_i.is_write) begin
        main_we = (op_i.region == REGION_MAIN);
        sec_we  = (op_i.region == REGION_SECOND);
        spad_we = (op_i.region == REGION_SCRATCH);
      end
    end
    main_re = pop_o && !op_i.is_write && (op_i.region == REGION_MAIN);
    sec_re  = pop_o && !op_i.is_write && (op_i.region == REGION_SECOND);
    spad_re = pop_o && !op_i.is_write && (op_i.region == REGION_SCRATCH);
  end

  mrmr_ram #(.DEPTH(MAIN_BYTES), .AW(MAIN_AW)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .re_i    (main_re),
    .addr_i  (main_addr),
    .wdata_i (wbyte),
    .rdata_o (main_rd)
  );

  mrmr_ram #(.DEPTH(SECOND_BYTES), .AW(SECOND_AW)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (sec_we),
    .re_i    (sec_re),
    .addr_i  (sec_addr),
    .wdata_i (wbyte),
    .rdata_o (sec_rd)
  );

  mrmr_ram #(.DEPTH(SCRATCH_BYTES), .AW(SCRATCH_AW)) u_spad_ram (
    .clk_i   (clk_i),
    .we_i    (spad_we),
    .re_i    (spad_re),
    .addr_i  (spad_addr),
    .wdata_i (wbyte),
    .rdata_o (spad_rd)
  );

  always_comb begin
    unique case (s1_region_q)
      REGION_SCRATCH: rd_byte = spad_rd;
      REGION_MAIN:    rd_byte = main_rd;
      REGION_SECOND:  rd_byte = sec_rd;
      default:        rd_byte = UNMAPPED_BYTE;
    endcase
    if (s1_first_q) begin
      acc_d        = {{(DATA_W - BYTE_W){1'b0}}, rd_byte};
      first_region = s1_region_q;
    end else begin
      acc_d        = {acc_q[DATA_W-BYTE_W-1:0], rd_byte};
      first_region = rgn_q;
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == CLR_W'(MAX_BYTES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    s1_vld_d  = s1_adv ? pop_o : s1_vld_q;
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_vld_q   <= s1_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_wr_q     <= op_i.is_write;
      s1_region_q <= op_i.region;
      s1_first_q  <= op_i.first;
      s1_last_q   <= op_i.last;
    end
    if (s1_fire) begin
      acc_q <= acc_d;
      rgn_q <= first_region;
    end
    if (out_load) begin
      read_data_o <= s1_wr_q ? '0 : acc_d;
      region_o    <= first_region;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mirrored_region_memory_router_top.sv
// ----------------------------------------------------------------------------
// mirrored_region_memory_router_top
// Bus access router onto scratchpad, main and second memories with mirrors.
// ----------------------------------------------------------------------------
// After reset the block clears all three memories, one byte of each per cycle,
// over as many addresses as the largest memory holds; input is stalled during
// that time while configuration writes are still taken. Each input word is
// then split into 1, 2 or 4 bytes by its access size, and the decoder issues
// one byte per cycle while the byte queue is not full. Bytes run through single
// ported byte-wide memories with registered reads; a result word is built in
// the back part and is registered at the output after its last byte is read.
`default_nettype none

module mirrored_region_memory_router_top
  import mrmr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 req_type_i,
  input  wire logic [ADDR_W-1:0]    address_i,
  input  wire logic [1:0]           access_size_i,
  input  wire logic [DATA_W-1:0]    write_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DATA_W-1:0]         read_data_o,
  output logic [1:0]                region_o
);

  cfg_t     cfg_q;
  logic     clearing;
  logic     q_push, q_full, q_pop, q_empty;
  byte_op_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.second_en <= 1'b0;
      cfg_q.spad_base <= SPAD_BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SECOND_EN: cfg_q.second_en <= cfg_data_i[0];
        default:       cfg_q.spad_base <= cfg_data_i;
      endcase
    end
  end

  mrmr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .clearing_i    (clearing),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .address_i     (address_i),
    .access_size_i (access_size_i),
    .write_data_i  (write_data_i),
    .push_o        (q_push),
    .push_data_o   (q_in),
    .full_i        (q_full)
  );

  mrmr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  mrmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .op_i        (q_out),
    .pop_o       (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .region_o    (region_o)
  );

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !(in_valid_i && !in_stall_o))
    else $error("Input accepted during the memory clearing pass.");

  a_clear_runs_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing |=> !clearing)
    else $error("Memory clearing pass restarted.");

  a_queue_empty_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (q_empty && !q_push && !out_valid_o))
    else $error("Byte operations present during the memory clearing pass.");
`endif

endmodule

`default_nettype wire

>>> sim/mrmr_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// mrmr_scoreboard_pkg
// Scoreboard for the mirrored region memory router testbench. It keeps its
// own copy of the three memories and the two registers, works out the reply
// to every accepted access, and compares the replies of the block in order.
// ----------------------------------------------------------------------------
package mrmr_scoreboard_pkg;

  import mrmr_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    region_e           region;
  } reply_t;

  class mrmr_scoreboard;

    logic [BYTE_W-1:0] main_mem   [MAIN_BYTES];
    logic [BYTE_W-1:0] second_mem [SECOND_BYTES];
    logic [BYTE_W-1:0] spad_mem   [SCRATCH_BYTES];
    logic              second_en;
    logic [ADDR_W-1:0] spad_base;
    reply_t            replies_q[$];
    int unsigned       errors;

    function new();
      foreach (main_mem[i]) main_mem[i] = '0;
      foreach (second_mem[i]) second_mem[i] = '0;
      foreach (spad_mem[i]) spad_mem[i] = '0;
      second_en = 1'b0;
      spad_base = SPAD_BASE_RESET;
      errors    = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_SECOND_EN: second_en = data[0];
        CFG_SPAD_BASE: spad_base = data;
        default: ;
      endcase
    endfunction

    function logic [ADDR_W-1:0] translate_addr(logic [ADDR_W-1:0] a);
      if ((a >= CACHED_LO && a < CACHED_HI) || (a >= UNCACHED_LO && a < UNCACHED_HI)) begin
        return a & MAIN_MASK;
      end
      if ((a >= SEC_CACHED_LO && a < SEC_CACHED_HI) ||
          (a >= SEC_UNCACHED_LO && a < SEC_UNCACHED_HI)) begin
        return a | SECOND_SEL;
      end
      return a;
    endfunction

    function region_e decode_byte(logic [ADDR_W-1:0] a, output int unsigned offset);
      logic [ADDR_W-1:0] phys;
      logic [ADDR_W:0]   spad_end;
      spad_end = {1'b0, spad_base} + SCRATCH_BYTES;
      if (a >= spad_base && {1'b0, a} < spad_end) begin
        offset = a - spad_base;
        return REGION_SCRATCH;
      end
      phys = translate_addr(a);
      if (phys < MAIN_BYTES) begin
        offset = phys;
        return REGION_MAIN;
      end
      if (second_en && (phys & SECOND_SEL) != '0 && (phys & SECOND_MASK) < SECOND_BYTES) begin
        offset = phys & SECOND_MASK;
        return REGION_SECOND;
      end
      offset = 0;
      return REGION_NONE;
    endfunction

    function void route_access(logic is_write, logic [ADDR_W-1:0] addr, logic [1:0] size,
                               logic [DATA_W-1:0] wdata);
      int unsigned       count;
      int unsigned       offset;
      int unsigned       k;
      logic [DATA_W-1:0] rdata;
      logic [BYTE_W-1:0] b;
      region_e           r;
      region_e           first_r;
      reply_t            rep;
      count   = (size == SIZE_BYTE) ? 1 : (size == SIZE_HALF) ? 2 : 4;
      rdata   = '0;
      first_r = REGION_NONE;
      for (k = 0; k < count; k++) begin
        r = decode_byte(addr + k, offset);
        if (k == 0) begin
          first_r = r;
        end
        if (is_write) begin
          b = 8'(wdata >> (8 * (count - 1 - k)));
          case (r)
            REGION_SCRATCH: spad_mem[offset] = b;
            REGION_MAIN:    main_mem[offset] = b;
            REGION_SECOND:  second_mem[offset] = b;
            default: ;
          endcase
        end else begin
          case (r)
            REGION_SCRATCH: b = spad_mem[offset];
            REGION_MAIN:    b = main_mem[offset];
            REGION_SECOND:  b = second_mem[offset];
            default:        b = UNMAPPED_BYTE;
          endcase
          rdata = {rdata[DATA_W-BYTE_W-1:0], b};
        end
      end
      rep.read_data = is_write ? '0 : rdata;
      rep.region    = first_r;
      replies_q.push_back(rep);
    endfunction

    function void check_reply(logic [DATA_W-1:0] rdata, logic [1:0] region);
      reply_t want;
      if (replies_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected reply read_data=%h region=%0d", $time, rdata, region);
        end
        return;
      end
      want = replies_q.pop_front();
      if (rdata !== want.read_data || region !== want.region) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: reply mismatch read_data exp %h got %h, region exp %0d got %0d",
                   $time, want.read_data, rdata, want.region, region);
        end
      end
    endfunction

  endclass

endpackage

>>> sim/mirrored_region_memory_router_top_tb.sv
// ----------------------------------------------------------------------------
// mirrored_region_memory_router_top_tb
// Drives bus access words into the router after its clearing pass, first a
// short directed list over every region, mirror and edge, then random words in
// several phases of register settings and sender and receiver idling. Every
// reply is checked against the scoreboard's own copy of the memories.
// ----------------------------------------------------------------------------
module mirrored_region_memory_router_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mrmr_pkg::*;
  import mrmr_scoreboard_pkg::*;

  localparam int unsigned STUCK_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 req_type_i;
  logic [ADDR_W-1:0]    address_i;
  logic [1:0]           access_size_i;
  logic [DATA_W-1:0]    write_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DATA_W-1:0]    read_data_o;
  logic [1:0]           region_o;

  mrmr_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  bit             hold_request;
  int unsigned    hold_left;
  int unsigned    stuck_cycles;
  bit             progress;

  mirrored_region_memory_router_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .address_i     (address_i),
    .access_size_i (access_size_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .region_o      (region_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_register(cfg_idx_e'(cfg_index_i), cfg_data_i);
        progress = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        sb.route_access(req_type_i, address_i, access_size_i, write_data_i);
        progress = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_reply(read_data_o, region_o);
        progress = 1'b1;
      end
      stuck_cycles = progress ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("mirrored_region_memory_router_top regression: fail");
        $finish;
      end
    end
  end

  task automatic write_cfg(cfg_idx_e idx, logic [DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_access(logic req, logic [ADDR_W-1:0] addr, logic [1:0] size,
                             logic [DATA_W-1:0] wdata);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    req_type_i    = req;
    address_i     = addr;
    access_size_i = size;
    write_data_i  = wdata;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.replies_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_offset(int unsigned span);
    case ($urandom_range(0, 9))
      7:       return $urandom_range(0, span - 1);
      8:       return span - 4 + $urandom_range(0, 3);
      9:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 11))
      0:       return CACHED_LO | pick_offset(MAIN_BYTES);
      1:       return UNCACHED_LO | pick_offset(MAIN_BYTES);
      2:       return pick_offset(MAIN_BYTES);
      3:       return SEC_CACHED_LO | pick_offset(SECOND_BYTES);
      4:       return SEC_UNCACHED_LO | pick_offset(SECOND_BYTES);
      5:       return SECOND_SEL | pick_offset(SECOND_BYTES);
      6:       return sb.spad_base + pick_offset(SCRATCH_BYTES + 4);
      7:       return CACHED_LO + $urandom_range(MAIN_BYTES, CACHED_HI - CACHED_LO + 3);
      8:       return SEC_CACHED_LO + $urandom_range(SECOND_BYTES, SEC_CACHED_HI - SEC_CACHED_LO);
      9:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [ADDR_W-1:0] phase_base [6];
    logic              phase_en   [6];
    int unsigned       phase_idle [6];
    int unsigned       phase_stall[6];
    phase_base  = '{32'hE000_0000, 32'hFFFF_F000, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_0000, 32'hC000_8000};
    phase_en    = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_idle  = '{0, 69, 0, 15, 0, 15};
    phase_stall = '{0, 0, 69, 15, 0, 15};
    sb            = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    req_type_i    = 1'b0;
    address_i     = '0;
    access_size_i = '0;
    write_data_i  = '0;
    out_stall_i   = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    stuck_cycles  = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    write_cfg(CFG_SECOND_EN, 32'd1);
    write_cfg(CFG_SPAD_BASE, SPAD_BASE_RESET);

    send_access(REQ_WRITE, 32'h8000_0000, SIZE_WORD, 32'h1122_3344);
    send_access(REQ_READ,  32'h0000_0000, SIZE_WORD, 32'h0);
    send_access(REQ_READ,  32'hC000_0001, SIZE_BYTE, 32'hFFFF_FFFF);
    send_access(REQ_WRITE, 32'h9000_0010, SIZE_HALF, 32'hA5A5_BEEF);
    send_access(REQ_READ,  32'hD000_000F, SIZE_WORD, 32'h0);
    send_access(REQ_READ,  32'h1000_0010, SIZE_HALF, 32'h0);
    send_access(REQ_WRITE, 32'hE000_0000, SIZE_WORD, 32'hFFFF_FFFF);
    send_access(REQ_WRITE, 32'hE000_3FFE, SIZE_WORD, 32'hCAFE_F00D);
    send_access(REQ_READ,  32'hE000_3FFE, SIZE_WORD, 32'h0);
    send_access(REQ_READ,  32'hE000_0000, SIZE_WORD, 32'h0);
    send_access(REQ_WRITE, 32'h8000_1000, 2'd3,      32'hDEAD_BEEF);
    send_access(REQ_READ,  32'h0000_1000, 2'd3,      32'h0);
    send_access(REQ_WRITE, 32'hFFFF_FFFF, SIZE_WORD, 32'h0102_0304);
    send_access(REQ_READ,  32'hFFFF_FFFE, SIZE_WORD, 32'h0);
    send_access(REQ_READ,  32'h0000_FFFE, SIZE_WORD, 32'h0);
    send_access(REQ_READ,  32'h8100_0000, SIZE_BYTE, 32'h0);
    send_access(REQ_READ,  32'h817F_FFFE, SIZE_WORD, 32'h0);
    send_access(REQ_READ,  32'h93FF_FFFF, SIZE_BYTE, 32'h0);
    send_access(REQ_WRITE, 32'h9000_FFFE, SIZE_WORD, 32'h5566_7788);
    send_access(REQ_READ,  32'hD000_FFFD, SIZE_WORD, 32'h0);
    send_access(REQ_WRITE, 32'h0001_0000, SIZE_BYTE, 32'h0000_00AA);
    send_access(REQ_READ,  32'hFFFF_FFFF, SIZE_BYTE, 32'h0);
    send_access(REQ_READ,  32'h7FFF_FFFF, SIZE_HALF, 32'h0);

    for (int p = 0; p < 6; p++) begin
      in_valid_i = 1'b0;
      wait_drained();
      write_cfg(CFG_SECOND_EN, {31'd0, phase_en[p]});
      write_cfg(CFG_SPAD_BASE, phase_base[p]);
      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      // The receiver holds off for a long stretch here so the block backs up.
      if (p == 4) begin
        hold_request = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        send_access(1'($urandom_range(0, 1)), pick_address(), 2'($urandom_range(0, 3)),
                    $urandom());
      end
    end

    in_valid_i = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.replies_q.size() == 0) begin
      $display("mirrored_region_memory_router_top regression: pass");
    end else begin
      $display("mirrored_region_memory_router_top regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/mrmr_pkg.sv
hdl/mrmr_ram.sv
hdl/mrmr_queue.sv
hdl/mrmr_front.sv
hdl/mrmr_back.sv
hdl/mirrored_region_memory_router_top.sv
sim/mrmr_scoreboard_pkg.sv
sim/mirrored_region_memory_router_top_tb.sv
